### rtl/wildcard_byte_pattern_scan_defines.svh
// Assertion helpers for the pattern scanner; clk and rst_n are taken from the using scope.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH

// Invariant checked at every edge outside reset.
`define WBPS_CHECK(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in the cycle after a trigger.
`define WBPS_CHECK_NEXT(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

### rtl/wbps_pkg.sv
`default_nettype none
package wbps_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 64;
  localparam logic [31:0] DEFAULT_START = 32'h0040_1000;
  localparam logic [31:0] DEFAULT_END   = 32'h07FF_FFFF;
  localparam logic [7:0]  WILD_BYTE     = 8'hFF;
  localparam logic [15:0] MATCH_SAT     = 16'hFFFF;
  localparam logic [7:0]  CHAR_WILD     = 8'h3F;  // '?'
  localparam logic [3:0]  HEX_TEN       = 4'hA;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_CHAR  = 2'd1,
    MODE_BYTE  = 2'd2,
    MODE_FAULT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OC_FOUND     = 2'd0,
    OC_NOT_FOUND = 2'd1,
    OC_BAD       = 2'd2,
    OC_FAULT     = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_SKIP  = 2'd2
  } cfg_reg_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic       clr;      // new search: wipe pattern and partial matches
    logic       wr_hex;   // add wr_val to the selected cell's byte
    logic       wr_wild;  // mark the selected cell as wildcard
    logic [7:0] wr_val;   // nibble already placed in its half
    logic       shift;    // memory byte beat, advance partial matches
    logic [7:0] mem_byte;
  } cell_ctrl_t;

  typedef struct packed {
    logic       valid;
    logic       wild;
    logic [3:0] val;
  } nib_dec_t;

  function automatic nib_dec_t decode_char(input logic [7:0] c);
    nib_dec_t d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.valid = 1'b1;
      d.val   = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.valid = 1'b1;
      d.val   = 4'(c - 8'h41) + HEX_TEN;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.valid = 1'b1;
      d.val   = 4'(c - 8'h61) + HEX_TEN;
    end else if (c == CHAR_WILD) begin
      d.valid = 1'b1;
      d.wild  = 1'b1;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

### rtl/wildcard_byte_pattern_scan.sv
`default_nettype none
// The output register takes a result at the edge that accepts the beat ending the search.
// Throughput: one input beat per cycle; input stalls only while a result beat waits.
// Each memory byte is checked against all pattern bytes in the same cycle by the cell row.
// Reset (rst_n low, synchronous) clears state registers, pattern cells and output valid.
// A clear beat (mode 0) wipes the pattern cells at once; no sweep is needed.
module wildcard_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] pattern_char, [15:8] memory_byte
  input  wire  [1:0]  in_tuser,   // [1:0] mode
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [0] found, [32:1] match_address, [39:33] zero
  output logic [1:0]  out_tuser,  // [1:0] outcome
  // configuration
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import wbps_pkg::*;

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);   // pattern length / byte index
  localparam int unsigned NW = LW + 1;                    // nibble count
  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // configuration registers
  logic [31:0] start_r, end_r;
  logic [15:0] skip_r;

  // search state
  logic [NW-1:0] nib_r, nib_nxt;
  logic          ovf_r, ovf_nxt;
  logic [15:0]   ms_r, ms_nxt;            // matches seen, saturating
  logic          search_done_r, search_done_nxt;
  logic          scan_r, scan_nxt;
  logic [LW-1:0] fill_r, fill_nxt;        // scan bytes taken, saturating at MAX_PATTERN
  logic [31:0]   cand_r, cand_nxt;        // start address of the next complete window
  logic [31:0]   last_r, last_nxt;        // last candidate address

  // output stage
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r;
  logic [31:0]   out_addr_r;
  outcome_t      out_oc_r;

  logic          emit, emit_found;
  logic [31:0]   emit_addr;
  outcome_t      emit_oc;

  logic          in_fire;
  mode_t         mode;
  logic [7:0]    p_char, m_byte;
  nib_dec_t      dec;
  cell_ctrl_t    ctrl;

  logic [LW-1:0] pat_len, len_m1, wr_idx;
  logic [IW-1:0] hit_idx;
  logic [31:0]   s_sel, e_sel, len_x, lim, cand_cur, last_cur;
  logic          idx_full, bad_pat, no_room, complete, full_hit;

  logic [MAX_PATTERN-1:0] part, cell_hit;

  assign mode   = mode_t'(in_tuser);
  assign p_char = in_tdata[7:0];
  assign m_byte = in_tdata[15:8];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign dec      = decode_char(p_char);
  assign wr_idx   = nib_r[NW-1:1];
  assign idx_full = wr_idx >= LW'(MAX_PATTERN);
  assign pat_len  = nib_r[NW-1:1];
  assign len_m1   = pat_len - 1'b1;
  assign hit_idx  = len_m1[IW-1:0];

  // scan window limits, taken on the first memory byte
  assign s_sel    = (start_r != '0) ? start_r : DEFAULT_START;
  assign e_sel    = (end_r   != '0) ? end_r   : DEFAULT_END;
  assign len_x    = {{(32-LW){1'b0}}, pat_len};
  assign lim      = e_sel - len_x;
  assign bad_pat  = nib_r[0] || ovf_r;
  assign no_room  = (pat_len == '0) || (e_sel < len_x) || (s_sel >= lim);
  assign cand_cur = scan_r ? cand_r : s_sel;
  assign last_cur = scan_r ? last_r : lim - 32'd1;

  // window is complete once pat_len bytes of this scan have arrived
  assign complete = fill_r >= len_m1;
  assign full_hit = complete && cell_hit[hit_idx];

  // pattern cell row: partial match flags walk one cell per memory byte
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic m_in;
    if (j == 0) begin : g_head
      assign m_in = 1'b1;
    end else begin : g_link
      assign m_in = part[j-1];
    end
    wbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .wr_sel    (wr_idx == LW'(j)),
      .match_in  (m_in),
      .match_out (part[j]),
      .hit       (cell_hit[j])
    );
  end

  always_comb begin
    nib_nxt         = nib_r;
    ovf_nxt         = ovf_r;
    ms_nxt          = ms_r;
    search_done_nxt = search_done_r;
    scan_nxt        = scan_r;
    fill_nxt        = fill_r;
    cand_nxt        = cand_r;
    last_nxt        = last_r;
    ctrl            = '0;
    ctrl.mem_byte   = m_byte;
    ctrl.wr_val     = nib_r[0] ? {4'h0, dec.val} : {dec.val, 4'h0};
    emit            = 1'b0;
    emit_found      = 1'b0;
    emit_addr       = '0;
    emit_oc         = OC_FOUND;

    if (in_fire) begin
      unique case (mode)
        MODE_CLEAR: begin
          ctrl.clr        = 1'b1;
          nib_nxt         = '0;
          ovf_nxt         = 1'b0;
          ms_nxt          = '0;
          search_done_nxt = 1'b0;
          scan_nxt        = 1'b0;
          fill_nxt        = '0;
        end
        MODE_CHAR: begin
          // characters after the scan started are dropped
          if (!search_done_r && !scan_r && dec.valid) begin
            if (idx_full) begin
              ovf_nxt = 1'b1;
            end else begin
              ctrl.wr_wild = dec.wild;
              ctrl.wr_hex  = !dec.wild;
              nib_nxt      = nib_r + 1'b1;
            end
          end
        end
        MODE_FAULT: begin
          if (!search_done_r) begin
            emit    = 1'b1;
            emit_oc = OC_FAULT;
          end
        end
        MODE_BYTE: begin
          if (!search_done_r) begin
            if (!scan_r && bad_pat) begin
              emit    = 1'b1;
              emit_oc = OC_BAD;
            end else if (!scan_r && no_room) begin
              emit    = 1'b1;
              emit_oc = OC_NOT_FOUND;
            end else begin
              scan_nxt   = 1'b1;
              ctrl.shift = 1'b1;
              last_nxt   = last_cur;
              cand_nxt   = cand_cur;
              if (fill_r != LW'(MAX_PATTERN)) begin
                fill_nxt = fill_r + 1'b1;
              end
              if (complete) begin
                if (full_hit && (ms_r >= skip_r)) begin
                  emit       = 1'b1;
                  emit_found = 1'b1;
                  emit_addr  = cand_cur;
                  emit_oc    = OC_FOUND;
                end else begin
                  if (full_hit && (ms_r != MATCH_SAT)) begin
                    ms_nxt = ms_r + 16'd1;
                  end
                  if (cand_cur == last_cur) begin
                    emit    = 1'b1;
                    emit_oc = OC_NOT_FOUND;
                  end else begin
                    cand_nxt = cand_cur + 32'd1;
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (emit) begin
      search_done_nxt = 1'b1;
    end
    out_valid_nxt = emit || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= '0;
      end_r         <= '0;
      skip_r        <= '0;
      nib_r         <= '0;
      ovf_r         <= 1'b0;
      ms_r          <= '0;
      search_done_r <= 1'b0;
      scan_r        <= 1'b0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START: start_r <= cfg_data;
          CFG_END:   end_r   <= cfg_data;
          CFG_SKIP:  skip_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      nib_r         <= nib_nxt;
      ovf_r         <= ovf_nxt;
      ms_r          <= ms_nxt;
      search_done_r <= search_done_nxt;
      scan_r        <= scan_nxt;
      fill_r        <= fill_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    last_r <= last_nxt;
    if (emit) begin
      out_found_r <= emit_found;
      out_addr_r  <= emit_addr;
      out_oc_r    <= emit_oc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_addr_r, out_found_r};
  assign out_tuser  = out_oc_r;

  // ---------------------------------------------------------------- checks
`include "wildcard_byte_pattern_scan_defines.svh"

  `WBPS_CHECK(a_result_ends_search, !out_valid_r || search_done_r, "result without finished search")
  `WBPS_CHECK(a_scan_needs_good_pattern, !scan_r || (!nib_r[0] && !ovf_r), "scan on bad pattern")
  `WBPS_CHECK_NEXT(a_quiet_after_done, in_fire && search_done_r && (mode != MODE_CLEAR), !out_valid_r, "result after finished search")

endmodule
`default_nettype wire

### rtl/wbps_cell.sv
`default_nettype none
module wbps_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire wbps_pkg::cell_ctrl_t ctrl,
  input  wire                     wr_sel,
  input  wire                     match_in,   // left neighbor's partial match
  output logic                    match_out,  // registered partial match
  output logic                    hit         // partial match ending at this beat
);
  import wbps_pkg::*;

  logic [7:0] pat_r;
  logic       wild_r;
  logic       part_r;
  logic       cmp;

  assign cmp       = wild_r || (pat_r == ctrl.mem_byte);
  assign hit       = match_in && cmp;
  assign match_out = part_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      pat_r  <= '0;
      wild_r <= 1'b0;
      part_r <= 1'b0;
    end else begin
      if (wr_sel && ctrl.wr_wild) begin
        pat_r  <= WILD_BYTE;
        wild_r <= 1'b1;
      end else if (wr_sel && ctrl.wr_hex) begin
        pat_r <= pat_r + ctrl.wr_val;
      end
      if (ctrl.shift) begin
        part_r <= hit;
      end
    end
  end

endmodule
`default_nettype wire

### tb/pattern_scan_checker.sv
module pattern_scan_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] pattern_char, [15:8] memory_byte
  input  wire  [1:0]  in_tuser,   // [1:0] mode
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [39:0] out_tdata,  // [0] found, [32:1] match_address, [39:33] zero
  input  wire  [1:0]  out_tuser,  // [1:0] outcome
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import wbps_pkg::*;

  localparam int PAT_MAX = 64;

  typedef struct packed {
    logic        found;
    logic [31:0] addr;
    outcome_t    outcome;
  } scan_outcome_t;

  scan_outcome_t outcome_q[$];

  logic [31:0] start_reg, end_reg;
  logic [15:0] skip_reg;

  logic [7:0]  pat_byte [PAT_MAX];
  logic        pat_wild [PAT_MAX];
  logic [7:0]  nib_cnt;
  logic        pat_ovf;
  logic [7:0]  window [PAT_MAX];
  logic [31:0] scan_addr, base_addr, cand_limit, pat_len;
  logic [15:0] match_cnt;
  logic        done, scanning;

  task automatic report_mismatch(string msg);
    $display("[%0t] scan check: %s", $time, msg);
    errors++;
  endtask

  function automatic void clear_search();
    int i;
    for (i = 0; i < PAT_MAX; i++) begin
      pat_byte[i] = '0;
      pat_wild[i] = 1'b0;
    end
    nib_cnt    = '0;
    pat_ovf    = 1'b0;
    scan_addr  = '0;
    base_addr  = '0;
    cand_limit = '0;
    pat_len    = '0;
    match_cnt  = '0;
    done       = 1'b0;
    scanning   = 1'b0;
  endfunction

  // One pattern text character: hex digits fill nibbles high first, '?' marks a wildcard byte.
  function automatic void add_pattern_char(logic [7:0] c);
    logic [3:0] nib;
    logic       is_wild;
    int         idx;
    idx     = nib_cnt >> 1;
    is_wild = 1'b0;
    nib     = '0;
    if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);
    else if (c == CHAR_WILD) is_wild = 1'b1;
    else return;
    if (idx >= PAT_MAX) begin
      pat_ovf = 1'b1;
      return;
    end
    if (is_wild) begin
      pat_byte[idx] = 8'hFF;
      pat_wild[idx] = 1'b1;
    end else begin
      pat_byte[idx] = pat_byte[idx] + (nib_cnt[0] ? {4'h0, nib} : {nib, 4'h0});
    end
    nib_cnt++;
  endfunction

  function automatic scan_outcome_t conclude(logic f, logic [31:0] a, outcome_t o);
    done = 1'b1;
    return '{found: f, addr: a, outcome: o};
  endfunction

  // Returns 1 when the beat ends the search with a result.
  function automatic bit predict_scan_step(mode_t mode, logic [7:0] ch, logic [7:0] mb,
                                           output scan_outcome_t res);
    logic [31:0] s, e, seen, cand;
    bit          hit;
    int          i;
    res = '0;
    if (mode == MODE_CLEAR) begin
      clear_search();
      return 0;
    end
    if (done) return 0;
    if (mode == MODE_FAULT) begin
      res = conclude(1'b0, '0, OC_FAULT);
      return 1;
    end
    if (mode == MODE_CHAR) begin
      if (!scanning) add_pattern_char(ch);
      return 0;
    end
    // first memory byte latches the bounds
    if (!scanning) begin
      s = (start_reg != 0) ? start_reg : DEFAULT_START;
      e = (end_reg != 0) ? end_reg : DEFAULT_END;
      if (nib_cnt[0] || pat_ovf) begin
        res = conclude(1'b0, '0, OC_BAD);
        return 1;
      end
      pat_len = 32'(nib_cnt >> 1);
      if (pat_len == 0 || e < pat_len || s >= e - pat_len) begin
        res = conclude(1'b0, '0, OC_NOT_FOUND);
        return 1;
      end
      scanning   = 1'b1;
      base_addr  = s;
      cand_limit = e - pat_len;
      scan_addr  = s;
    end
    for (i = 0; i < PAT_MAX - 1; i++) window[i] = window[i + 1];
    window[PAT_MAX - 1] = mb;
    seen = scan_addr - base_addr + 32'd1;
    scan_addr++;
    if (seen < pat_len) return 0;
    cand = scan_addr - pat_len;
    hit  = 1'b1;
    for (i = 0; i < pat_len; i++)
      if (!pat_wild[i] && pat_byte[i] != window[PAT_MAX - pat_len + i]) hit = 1'b0;
    if (hit) begin
      if (match_cnt >= skip_reg) begin
        res = conclude(1'b1, cand, OC_FOUND);
        return 1;
      end
      if (match_cnt != MATCH_SAT) match_cnt++;
    end
    if (cand + 32'd1 >= cand_limit) begin
      res = conclude(1'b0, '0, OC_NOT_FOUND);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    scan_outcome_t want, res;
    int i;
    if (!rst_n) begin
      clear_search();
      for (i = 0; i < PAT_MAX; i++) window[i] = '0;
      start_reg = '0;
      end_reg   = '0;
      skip_reg  = '0;
      outcome_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START: start_reg = cfg_data;
          CFG_END:   end_reg   = cfg_data;
          CFG_SKIP:  skip_reg  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat found=%0b addr=%h outcome=%0d",
                                    out_tdata[0], out_tdata[32:1], out_tuser));
        end else begin
          want = outcome_q.pop_front();
          if (out_tdata[0] !== want.found)
            report_mismatch($sformatf("found got %0b want %0b", out_tdata[0], want.found));
          if (out_tdata[32:1] !== want.addr)
            report_mismatch($sformatf("match_address got %h want %h",
                                      out_tdata[32:1], want.addr));
          if (out_tuser !== want.outcome)
            report_mismatch($sformatf("outcome got %0d want %0d", out_tuser, want.outcome));
          if (out_tdata[39:33] !== '0)
            report_mismatch($sformatf("tdata pad bits got %h", out_tdata[39:33]));
        end
      end
      if (in_tvalid && in_tready) begin
        if (predict_scan_step(mode_t'(in_tuser), in_tdata[7:0], in_tdata[15:8], res))
          outcome_q.push_back(res);
      end
    end
    pending = outcome_q.size();
  end

endmodule

### tb/tb.sv
module tb;
  import wbps_pkg::*;

  localparam int PAT_BYTES = 64;
  localparam int MAX_SCAN  = 96;   // memory beats per search when the bounds are wide

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [15:0] in_tdata;            // [7:0] pattern_char, [15:8] memory_byte
  logic [1:0]  in_tuser;            // [1:0] mode
  logic        out_tvalid, out_tready;
  logic [39:0] out_tdata;           // [0] found, [32:1] match_address, [39:33] zero
  logic [1:0]  out_tuser;           // [1:0] outcome
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int errors, pending;

  // stimulus knobs, changed between phases
  int snd_idle, rcv_idle;
  bit hold_armed;
  int items_sent;
  logic [31:0] scan_lo, scan_hi;    // effective scan bounds of the current setting

  // pattern and memory image of the search being built
  logic [7:0] pat_val [PAT_BYTES];
  bit         pat_is_wild [PAT_BYTES];
  logic [7:0] mem_img [MAX_SCAN + 4];

  wildcard_byte_pattern_scan uut (.*);
  pattern_scan_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("wildcard_byte_pattern_scan: mismatch");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off so the output stage
  // fills and the block has to stall its input while the sender keeps offering.
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !held) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // One input beat; optional idle cycles first, then hold until accepted.
  // Returns at the falling edge after the accepting edge, tvalid still high.
  task automatic send_beat(mode_t mode, logic [7:0] ch, logic [7:0] mb);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {mb, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(string txt);
    int i;
    for (i = 0; i < txt.len(); i++) send_beat(MODE_CHAR, txt[i], 8'($urandom));
  endtask

  // Wait out every expected result, then leave a margin before returning.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // All three registers in back-to-back writes; only called while idle.
  task automatic set_config(logic [31:0] lo, logic [31:0] hi, logic [15:0] skip);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= CFG_END;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_index <= CFG_SKIP;
    cfg_data  <= {16'h0, skip};
    @(negedge clk);
    cfg_we  <= 1'b0;
    scan_lo = (lo != 0) ? lo : DEFAULT_START;
    scan_hi = (hi != 0) ? hi : DEFAULT_END;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < HEX_TEN) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n - HEX_TEN);
  endfunction

  // characters the parser skips: separators, non-hex letters, high-bit bytes
  function automatic logic [7:0] junk_char();
    case ($urandom_range(4))
      0:       return 8'h20;
      1:       return 8'h67;
      2:       return 8'h5A;
      3:       return 8'h2D;
      default: return 8'h80 | 8'($urandom_range(127));
    endcase
  endfunction

  task automatic send_char(logic [7:0] c);
    if ($urandom_range(11) == 0) send_beat(MODE_CHAR, junk_char(), 8'($urandom));
    send_beat(MODE_CHAR, c, 8'($urandom));
  endtask

  // A wildcard byte may be spelled "??", "?h" or "h?": the mark survives either way.
  task automatic send_pattern_byte(logic [7:0] b, bit wild);
    if (wild) begin
      case ($urandom_range(2))
        0: begin
          send_char(CHAR_WILD);
          send_char(CHAR_WILD);
        end
        1: begin
          send_char(CHAR_WILD);
          send_char(hex_char(4'($urandom)));
        end
        default: begin
          send_char(hex_char(4'($urandom)));
          send_char(CHAR_WILD);
        end
      endcase
    end else begin
      send_char(hex_char(b[7:4]));
      send_char(hex_char(b[3:0]));
    end
  endtask

  // New bounds for a phase: defaults, top of the address space, tiny and
  // inverted ranges, and now and then fully random values.
  task automatic pick_config();
    logic [31:0] lo, hi;
    logic [15:0] skip;
    int j;
    case ($urandom_range(5))
      0: begin
        lo = '0;
        hi = DEFAULT_START + $urandom_range(4, 60);
      end
      1: begin
        lo = DEFAULT_END - $urandom_range(8, 60);
        hi = '0;
      end
      2: begin
        lo = 32'hFFFF_FFFF - $urandom_range(8, 60);
        hi = 32'hFFFF_FFFF;
      end
      3: begin
        lo = $urandom;
        hi = lo + $urandom_range(2, 60);
      end
      4: begin
        lo = $urandom_range(1, 40);
        hi = $urandom_range(0, 48);
      end
      default: begin
        lo = $urandom;
        hi = $urandom;
      end
    endcase
    j = $urandom_range(19);
    skip = (j == 0) ? 16'hFFFF : (j < 10) ? 16'd0 : 16'($urandom_range(1, 3));
    set_config(lo, hi, skip);
  endtask

  // One search: mostly well-formed (clear, pattern text, memory stream with
  // planted copies), some broken on purpose, some pure noise.
  task automatic run_search();
    int kind, flaw, len, nbytes, pos, fault_at, i, j;
    longint span;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(5, 20))
        send_beat(mode_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
      return;
    end
    flaw = (kind >= 70) ? $urandom_range(3) : -1;

    j = $urandom_range(99);
    len = (j < 80) ? $urandom_range(1, 6) :
          (j < 95) ? $urandom_range(7, 20) : $urandom_range(21, PAT_BYTES);
    for (i = 0; i < len; i++) begin
      pat_is_wild[i] = ($urandom_range(5) == 0);
      pat_val[i]     = 8'($urandom);
    end

    // a missing clear lets the beats land on whatever search is still open
    if ($urandom_range(32) != 0) send_beat(MODE_CLEAR, 8'($urandom), 8'($urandom));
    if (flaw != 2) begin
      for (i = 0; i < len; i++) send_pattern_byte(pat_val[i], pat_is_wild[i]);
    end
    if (flaw == 0) send_char(hex_char(4'($urandom)));            // odd nibble count
    if (flaw == 1) repeat (PAT_BYTES + 1 - len) send_pattern_byte(8'h00, 1'b0);  // overflow

    span = longint'(scan_hi) - longint'(scan_lo);
    nbytes = (span <= 0) ? $urandom_range(1, 3) :
             (span > MAX_SCAN) ? MAX_SCAN : int'(span) + $urandom_range(0, 2);
    // half of the filler comes from the pattern's own bytes to provoke natural hits
    for (i = 0; i < nbytes; i++)
      mem_img[i] = $urandom_range(1) ? 8'($urandom) : pat_val[$urandom_range(len - 1)];
    if (nbytes >= len) begin
      repeat ($urandom_range(0, 3)) begin
        pos = $urandom_range(nbytes - len);
        for (j = 0; j < len; j++)
          if (!pat_is_wild[j]) mem_img[pos + j] = pat_val[j];
      end
    end

    fault_at = (flaw == 3 || $urandom_range(11) == 0) ? $urandom_range(nbytes - 1) : -1;
    for (i = 0; i < nbytes; i++) begin
      if (i == fault_at) send_beat(MODE_FAULT, 8'($urandom), 8'($urandom));
      send_beat(MODE_BYTE, 8'($urandom), mem_img[i]);
      // pattern text after the scan has begun must be ignored
      if (i == 0 && $urandom_range(9) == 0)
        send_beat(MODE_CHAR, hex_char(4'($urandom)), 8'($urandom));
    end
    // stray beats after the memory stream, whether or not the search has finished
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 4))
        send_beat(mode_t'($urandom_range(1, 3)), 8'($urandom), 8'($urandom));
  endtask

  initial begin : stimulus
    int regime, phase_end;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_CLEAR;
    cfg_we     = 1'b0;
    cfg_index  = CFG_START;
    cfg_data   = '0;
    snd_idle   = 11;
    rcv_idle   = 63;
    hold_armed = 1'b0;
    items_sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, default bounds
    set_config('0, '0, '0);
    // odd nibble count -> bad pattern
    send_beat(MODE_CLEAR, 8'h00, 8'h00);
    send_text("?");
    send_beat(MODE_BYTE, 8'h00, 8'h00);
    // empty pattern -> not found
    send_beat(MODE_CLEAR, 8'hFF, 8'hFF);
    send_beat(MODE_BYTE, 8'h00, 8'hFF);
    // mixed case hex, a wildcard byte, skipped chars; hit at the default start
    send_beat(MODE_CLEAR, 8'h00, 8'h00);
    send_text("Ab??");
    send_beat(MODE_CHAR, 8'h00, 8'h00);
    send_beat(MODE_CHAR, 8'hFF, 8'hFF);
    send_beat(MODE_BYTE, 8'h00, 8'hAB);
    send_beat(MODE_BYTE, 8'hFF, 8'h00);
    // finished search ignores everything but a clear
    send_beat(MODE_CHAR, 8'h31, 8'h00);
    send_beat(MODE_FAULT, 8'h00, 8'h00);
    // wildcards spelled "5?" and "?7": both bytes are wild, first window hits
    send_beat(MODE_CLEAR, 8'h00, 8'h00);
    send_text("5??7");
    send_beat(MODE_BYTE, 8'h00, 8'hFF);
    send_beat(MODE_BYTE, 8'h00, 8'h00);
    // late pattern char ignored, then a fault mid-scan
    send_beat(MODE_CLEAR, 8'h00, 8'h00);
    send_text("ff");
    send_beat(MODE_BYTE, 8'h00, 8'h00);
    send_beat(MODE_CHAR, 8'h31, 8'h00);
    send_beat(MODE_FAULT, 8'hFF, 8'hFF);
    settle();

    // start not below end minus length
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(MODE_CLEAR, 8'h00, 8'h00);
    send_text("00");
    send_beat(MODE_BYTE, 8'h00, 8'h00);
    settle();

    // end below the pattern length
    set_config(32'd5, 32'd1, 16'd1);
    send_beat(MODE_CLEAR, 8'h00, 8'h00);
    send_text("0000");
    send_beat(MODE_BYTE, 8'h00, 8'h00);
    settle();

    // Random part: three idling regimes, several bound settings each
    for (regime = 0; regime < 3; regime++) begin
      snd_idle = (regime == 0) ? 11 : (regime == 1) ? 63 : 0;
      rcv_idle = (regime == 0) ? 63 : (regime == 1) ? 11 : 0;
      repeat (4) begin
        pick_config();
        if (regime == 2) hold_armed = 1'b1;
        phase_end = items_sent + 150;
        while (items_sent < phase_end) run_search();
        settle();
      end
    end

    if (errors == 0) begin
      $display("wildcard_byte_pattern_scan: match");
    end else begin
      $display("wildcard_byte_pattern_scan: mismatch");
    end
    $finish;
  end

endmodule

### wildcard_byte_pattern_scan.f
+incdir+rtl
rtl/wbps_pkg.sv
rtl/wbps_cell.sv
rtl/wildcard_byte_pattern_scan.sv
tb/pattern_scan_checker.sv
tb/tb.sv
